// ----- rtl/core/dtmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF generator package
// Shared constants, types and the elaboration-time sine builder.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF     = 16;
  localparam int unsigned SAMPLE_RATE_DEF     = 8000;
  localparam int unsigned PHASE_BITS_DEF      = 24;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned KEY_W    = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd2;

  localparam logic [LEN_W-1:0] TONE_SAMPLES_RST = 16'd800;
  localparam logic [LEN_W-1:0] GAP_SAMPLES_RST  = 16'd800;
  localparam logic [AMP_W-1:0] AMPLITUDE_RST    = 15'd16000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int unsigned FREQ_LOW [16] = '{
    941, 697, 697, 697, 770, 770, 770, 852, 852, 852, 941, 941, 697, 770, 852, 941
  };
  localparam int unsigned FREQ_HIGH [16] = '{
    1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209, 1336, 1477, 1209, 1477,
    1633, 1633, 1633, 1633
  };

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } fifo_status_t;

  // quarter-wave sine in Q1.15, Taylor series in Q2.30
  function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input int unsigned j,
                                                               input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] scaled;
    x    = ((64'(j) * TWO_PI_Q30) + ((64'd1 << tbits) >> 1)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    scaled = ((64'(sum) * 64'd32767) + (ONE_Q30 >> 1)) >> 30;
    return scaled[SAMPLE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/dtmf_sequence_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF sequence generator core
// Queues key loads and plays each key as a dual tone followed by a gap.
// Pipeline: ROM read into the stage-1 registers, then sine sum and amplitude
// multiply into the output register.
// Throughput: one beat per cycle while in_stall_o is low; segment and phase
// state update in the accept cycle, so beats may follow each other directly.
// Reset: asynchronous, clears queue pointers, segment state and pipeline valids;
// configuration returns to 800 / 800 / 16000.
// ----------------------------------------------------------------------------
module dtmf_sequence_generator_core #(
  parameter int unsigned QUEUE_DEPTH     = dtmf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned SAMPLE_RATE     = dtmf_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned PHASE_BITS      = dtmf_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = dtmf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [dtmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [dtmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   cmd_i,
  input  logic        [dtmf_pkg::KEY_W-1:0]      key_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                   key_accepted_o,
  output logic                                   busy_res_o
);
  import dtmf_pkg::*;

  typedef logic [PHASE_BITS-1:0] inc_tab_t [16];

  function automatic logic [PHASE_BITS-1:0] phase_inc(input int unsigned f);
    logic [63:0] v;
    v = ((64'(f) << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
    return v[PHASE_BITS-1:0];
  endfunction

  function automatic inc_tab_t build_inc(input logic high);
    inc_tab_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = high ? phase_inc(FREQ_HIGH[i]) : phase_inc(FREQ_LOW[i]);
    end
    return t;
  endfunction

  localparam inc_tab_t INC_LOW  = build_inc(1'b0);
  localparam inc_tab_t INC_HIGH = build_inc(1'b1);

  // configuration
  logic [LEN_W-1:0] tone_len_q, gap_len_q;
  logic [AMP_W-1:0] amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_len_q <= TONE_SAMPLES_RST;
      gap_len_q  <= GAP_SAMPLES_RST;
      amp_q      <= AMPLITUDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TONE_SAMPLES: tone_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_GAP_SAMPLES:  gap_len_q  <= cfg_data_i[LEN_W-1:0];
        CFG_AMPLITUDE:    amp_q      <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q, s1_valid_q;
  logic out_free, accept, is_load, is_tick;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = accept && (cmd_i == CMD_LOAD);
  assign is_tick    = accept && (cmd_i == CMD_TICK);

  // segment state
  logic [KEY_W-1:0]      cur_key_q, cur_key_d;
  logic [LEN_W-1:0]      seg_left_q, seg_left_d;
  logic                  in_gap_q, in_gap_d;
  logic                  seg_active_q, seg_active_d;
  logic [PHASE_BITS-1:0] ph_lo_q, ph_lo_d, ph_hi_q, ph_hi_d;

  // key queue
  fifo_status_t     fifo_st;
  logic [KEY_W-1:0] head_key;
  logic             push, pop, start;

  assign start = !seg_active_q && !fifo_st.empty;
  assign push  = is_load && !fifo_st.full;
  assign pop   = is_tick && start;

  dtmf_key_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .key_i    (key_i),
    .head_o   (head_key),
    .status_o (fifo_st)
  );

  logic [KEY_W-1:0]      eff_key;
  logic [LEN_W-1:0]      eff_left, left_dec;
  logic                  eff_gap, eff_active, tone_on, busy_tick;
  logic [PHASE_BITS-1:0] eff_ph_lo, eff_ph_hi;

  always_comb begin
    eff_key    = cur_key_q;
    eff_left   = seg_left_q;
    eff_gap    = in_gap_q;
    eff_active = seg_active_q;
    eff_ph_lo  = ph_lo_q;
    eff_ph_hi  = ph_hi_q;
    if (start) begin
      eff_key   = head_key;
      eff_ph_lo = '0;
      eff_ph_hi = '0;
      if (tone_len_q != '0) begin
        eff_gap    = 1'b0;
        eff_left   = tone_len_q;
        eff_active = 1'b1;
      end else if (gap_len_q != '0) begin
        eff_gap    = 1'b1;
        eff_left   = gap_len_q;
        eff_active = 1'b1;
      end else begin
        eff_gap    = 1'b0;
        eff_left   = '0;
        eff_active = 1'b0;
      end
    end

    tone_on  = eff_active && !eff_gap;
    left_dec = (eff_left != '0) ? eff_left - LEN_W'(1) : '0;

    cur_key_d    = eff_key;
    seg_left_d   = eff_left;
    in_gap_d     = eff_gap;
    seg_active_d = eff_active;
    ph_lo_d      = eff_ph_lo;
    ph_hi_d      = eff_ph_hi;
    if (eff_active) begin
      if (tone_on) begin
        ph_lo_d = eff_ph_lo + INC_LOW[eff_key];
        ph_hi_d = eff_ph_hi + INC_HIGH[eff_key];
      end
      seg_left_d = left_dec;
      if (left_dec == '0) begin
        if (tone_on && (gap_len_q != '0)) begin
          in_gap_d   = 1'b1;
          seg_left_d = gap_len_q;
          ph_lo_d    = '0;
          ph_hi_d    = '0;
        end else begin
          in_gap_d     = 1'b0;
          seg_active_d = 1'b0;
        end
      end
    end

    busy_tick = seg_active_d || (!fifo_st.empty && !(start && fifo_st.single));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_key_q    <= '0;
      seg_left_q   <= '0;
      in_gap_q     <= 1'b0;
      seg_active_q <= 1'b0;
      ph_lo_q      <= '0;
      ph_hi_q      <= '0;
    end else if (is_tick) begin
      cur_key_q    <= cur_key_d;
      seg_left_q   <= seg_left_d;
      in_gap_q     <= in_gap_d;
      seg_active_q <= seg_active_d;
      ph_lo_q      <= ph_lo_d;
      ph_hi_q      <= ph_hi_d;
    end
  end

  // stage 1: sine lookup
  logic signed [SAMPLE_W-1:0] sine_lo, sine_hi;

  dtmf_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (accept),
    .addr_a_i (eff_ph_lo[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .addr_b_i (eff_ph_hi[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .data_a_o (sine_lo),
    .data_b_o (sine_hi)
  );

  logic             s1_tone_q, s1_acc_q, s1_busy_q;
  logic [AMP_W-1:0] s1_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !out_free);
      out_valid_q <= (s1_valid_q && out_free) || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tone_q <= is_tick && tone_on;
      s1_acc_q  <= push;
      s1_busy_q <= is_load ? 1'b1 : busy_tick;
      s1_amp_q  <= amp_q;
    end
  end

  // stage 2: mean of the two sines scaled by amplitude, truncated toward zero
  logic signed [SAMPLE_W:0]     sine_sum;
  logic signed [2*SAMPLE_W:0]   prod, prod_adj;
  logic signed [SAMPLE_W-1:0]   sample_d, sample_q;
  logic                         acc_q, busy_q;

  always_comb begin
    sine_sum = {sine_lo[SAMPLE_W-1], sine_lo} + {sine_hi[SAMPLE_W-1], sine_hi};
    prod     = $signed({1'b0, s1_amp_q}) * sine_sum;
    prod_adj = prod[2*SAMPLE_W] ? prod + (2*SAMPLE_W+1)'(65535) : prod;
    sample_d = s1_tone_q ? prod_adj[2*SAMPLE_W-1:SAMPLE_W] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      sample_q <= sample_d;
      acc_q    <= s1_acc_q;
      busy_q   <= s1_busy_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign key_accepted_o = acc_q;
  assign busy_res_o     = busy_q;

endmodule

// ----- rtl/core/dtmf_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF sine ROM
// Dual-port full-wave Q1.15 sine table with registered read data.
// ----------------------------------------------------------------------------
module dtmf_sine_rom #(
  parameter int unsigned TABLE_BITS = dtmf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [TABLE_BITS-1:0]         addr_a_i,
  input  logic        [TABLE_BITS-1:0]         addr_b_i,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] data_a_o,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] data_b_o
);
  import dtmf_pkg::*;

  localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
  localparam int unsigned QUARTER    = TABLE_SIZE / 4;

  typedef logic signed [SAMPLE_W-1:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t              rom;
    int unsigned       q;
    int unsigned       r;
    logic signed [SAMPLE_W-1:0] v;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
      q = i / QUARTER;
      r = i % QUARTER;
      v = ((q % 2) == 1) ? quarter_sine(QUARTER - r, TABLE_BITS)
                         : quarter_sine(r, TABLE_BITS);
      rom[i] = ((q / 2) == 1) ? -v : v;
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [SAMPLE_W-1:0] data_a_q;
  logic signed [SAMPLE_W-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SINE_ROM[addr_a_i];
      data_b_q <= SINE_ROM[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ----- rtl/core/dtmf_key_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF key FIFO
// Circular key queue with a registered head entry and write bypass.
// ----------------------------------------------------------------------------
module dtmf_key_fifo #(
  parameter int unsigned DEPTH = dtmf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           pop_i,
  input  logic [dtmf_pkg::KEY_W-1:0]     key_i,
  output logic [dtmf_pkg::KEY_W-1:0]     head_o,
  output dtmf_pkg::fifo_status_t         status_o
);
  import dtmf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] head_q;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      count_d  = count_q + CNT_W'(1);
    end else if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      count_d  = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= key_i;
    end
    if (push_i && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= key_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  assign head_o          = head_q;
  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == CNT_W'(DEPTH));
  assign status_o.single = (count_q == CNT_W'(1));

endmodule

// ----- tb/dtmf_sequence_generator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF sequence generator core testbench
// Feeds key loads and sample ticks under random sender bursts and receiver
// stalls. A built-in tone predictor works out the sample, accept flag and busy
// flag for each accepted beat, and each output beat is checked against them.
// Settings are changed only while no beat is in flight.
// ----------------------------------------------------------------------------
module dtmf_sequence_generator_core_test;
  import dtmf_pkg::*;

  localparam int unsigned LUT_BITS    = SINE_TABLE_BITS_DEF;
  localparam int unsigned LUT_SIZE    = 1 << LUT_BITS;
  localparam int unsigned PH_W        = PHASE_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_CHUNK = 16;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } dtmf_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       key_accepted;
    logic                       busy;
  } tone_result_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic        [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic                         cmd_i          = CMD_LOAD;
  logic        [KEY_W-1:0]      key_i          = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_o;
  logic                         key_accepted_o;
  logic                         busy_res_o;

  // tone predictor state
  logic signed [SAMPLE_W-1:0] sine_lut [LUT_SIZE];
  logic [LEN_W-1:0]  tone_len = TONE_SAMPLES_RST;
  logic [LEN_W-1:0]  gap_len  = GAP_SAMPLES_RST;
  logic [AMP_W-1:0]  amp_reg  = AMPLITUDE_RST;
  logic [KEY_W-1:0]  key_store [QUEUE_DEPTH_DEF];
  logic [KEY_W-1:0]  q_rd     = '0;
  logic [KEY_W-1:0]  q_wr     = '0;
  int unsigned       q_count  = 0;
  logic [KEY_W-1:0]  cur_key  = '0;
  logic [LEN_W-1:0]  seg_left = '0;
  logic              gap_on   = 1'b0;
  logic              seg_on   = 1'b0;
  logic [PH_W-1:0]   ph_low   = '0;
  logic [PH_W-1:0]   ph_high  = '0;

  dtmf_beat_t   pending_beats [$];
  tone_result_t expected_res [$];
  dtmf_beat_t   next_beat;
  tone_result_t want;

  bit          beat_taken   = 1'b0;
  bit          steady_flow  = 1'b0;
  bit          stall_on     = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_run    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatch_cnt = 0;

  dtmf_sequence_generator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o),
    .key_accepted_o(key_accepted_o),
    .busy_res_o    (busy_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // quarter-wave sine in Q1.15 from a Q2.30 Taylor series
  function automatic int quarter_wave(input int unsigned j);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] t;
    longint      acc;
    ang  = (64'(j) * TWO_PI_Q30 + 64'(LUT_SIZE / 2)) >> LUT_BITS;
    ang2 = (ang * ang) >> 30;
    t    = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 8; k++) begin
      t = ((t * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(t);
      else            acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return int'((64'(acc) * 64'd32767 + (ONE_Q30 >> 1)) >> 30);
  endfunction

  function automatic void build_lut();
    int unsigned qw;
    int unsigned qd;
    int unsigned rm;
    int          v;
    qw = LUT_SIZE / 4;
    for (int i = 0; i < LUT_SIZE; i++) begin
      qd = i / qw;
      rm = i % qw;
      v  = qd[0] ? quarter_wave(qw - rm) : quarter_wave(rm);
      sine_lut[i] = SAMPLE_W'(qd[1] ? -v : v);
    end
  endfunction

  function automatic logic [PH_W-1:0] phase_step(input int unsigned f);
    logic [63:0] v;
    v = ((64'(f) << PH_W) + 64'(SAMPLE_RATE_DEF / 2)) / 64'(SAMPLE_RATE_DEF);
    return v[PH_W-1:0];
  endfunction

  function automatic tone_result_t predict_tone(input logic cmd, input logic [KEY_W-1:0] key);
    tone_result_t r;
    int           pair;
    longint       prod;
    r.pcm          = '0;
    r.key_accepted = 1'b0;
    if (cmd == CMD_LOAD) begin
      if (q_count < QUEUE_DEPTH_DEF) begin
        key_store[q_wr] = key;
        q_wr++;
        q_count++;
        r.key_accepted = 1'b1;
      end
    end else begin
      if (!seg_on && q_count != 0) begin
        cur_key = key_store[q_rd];
        q_rd++;
        q_count--;
        ph_low  = '0;
        ph_high = '0;
        if (tone_len != 0) begin
          gap_on   = 1'b0;
          seg_left = tone_len;
          seg_on   = 1'b1;
        end else if (gap_len != 0) begin
          gap_on   = 1'b1;
          seg_left = gap_len;
          seg_on   = 1'b1;
        end else begin
          gap_on   = 1'b0;
          seg_left = '0;
          seg_on   = 1'b0;
        end
      end
      if (seg_on) begin
        if (!gap_on) begin
          pair  = int'(sine_lut[ph_low[PH_W-1 -: LUT_BITS]]);
          pair += int'(sine_lut[ph_high[PH_W-1 -: LUT_BITS]]);
          prod  = longint'(amp_reg) * longint'(pair);
          r.pcm = SAMPLE_W'(prod / 65536);
          ph_low  = ph_low + phase_step(FREQ_LOW[cur_key]);
          ph_high = ph_high + phase_step(FREQ_HIGH[cur_key]);
        end
        if (seg_left != 0) seg_left--;
        if (seg_left == 0) begin
          if (!gap_on && gap_len != 0) begin
            gap_on   = 1'b1;
            seg_left = gap_len;
            ph_low   = '0;
            ph_high  = '0;
          end else begin
            gap_on = 1'b0;
            seg_on = 1'b0;
          end
        end
      end
    end
    r.busy = seg_on || (q_count != 0);
    return r;
  endfunction

  function automatic void push_load(input int unsigned k);
    pending_beats.push_back('{CMD_LOAD, KEY_W'(k)});
  endfunction

  function automatic void push_tick();
    pending_beats.push_back('{CMD_TICK, KEY_W'($urandom_range(0, 15))});
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TONE_SAMPLES: tone_len = val[LEN_W-1:0];
      CFG_GAP_SAMPLES:  gap_len  = val[LEN_W-1:0];
      CFG_AMPLITUDE:    amp_reg  = val[AMP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_res.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // tick until the queue and any tone or gap have played out
  task automatic drain_tones();
    settle();
    while (seg_on || q_count != 0) begin
      repeat (DRAIN_CHUNK) push_tick();
      settle();
    end
  endtask

  task automatic random_phase(input int unsigned n, input bit pause_mid);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        repeat ($urandom_range(6, 20)) push_load($urandom_range(0, 15));
      end else if (r < 15) begin
        push_load($urandom_range(0, 15));
      end else begin
        push_tick();
      end
    end
    drain_tones();
  endtask

  // sender: bursts with gaps; receiver: own stall pattern
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      beat_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = (steady_flow || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        cmd_i      <= next_beat.cmd;
        key_i      <= next_beat.key;
        in_valid_i <= 1'b1;
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (steady_flow) begin
      stall_on  = 1'b0;
      stall_run = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on  = !stall_on;
        stall_run = stall_on ? $urandom_range(1, 8)
                             : (($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20));
      end
      stall_run--;
      out_stall_i <= stall_on;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beat_taken = 1'b1;
        expected_res.push_back(predict_tone(cmd_i, key_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected beat: pcm %0d acc %0b busy %0b",
                     $time, sample_o, key_accepted_o, busy_res_o);
        end else begin
          want = expected_res.pop_front();
          if (want.pcm !== sample_o || want.key_accepted !== key_accepted_o ||
              want.busy !== busy_res_o) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: exp pcm %0d acc %0b busy %0b, got pcm %0d acc %0b busy %0b",
                       $time, want.pcm, want.key_accepted, want.busy,
                       sample_o, key_accepted_o, busy_res_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    build_lut();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: idle tick on empty queue, then one key; gap cut short mid-tone
    push_tick();
    push_load(1);
    repeat (8) push_tick();
    settle();
    write_reg(CFG_GAP_SAMPLES, 16'd2);
    drain_tones();

    // every key, then a load into a full queue
    write_reg(CFG_TONE_SAMPLES, 16'd2);
    write_reg(CFG_GAP_SAMPLES, 16'd1);
    write_reg(CFG_AMPLITUDE, 16'hFFFF);
    for (int k = 0; k < 16; k++) push_load(k);
    push_load(9);
    drain_tones();

    // zero-length tone
    write_reg(CFG_TONE_SAMPLES, 16'd0);
    write_reg(CFG_GAP_SAMPLES, 16'd3);
    write_reg(CFG_AMPLITUDE, 16'd8000);
    push_load(12);
    push_tick();
    drain_tones();

    // zero-length gap
    write_reg(CFG_TONE_SAMPLES, 16'd3);
    write_reg(CFG_GAP_SAMPLES, 16'd0);
    push_load(11);
    push_load(10);
    drain_tones();

    // both zero; spare index must be ignored
    write_reg(CFG_TONE_SAMPLES, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    push_load(7);
    push_load(15);
    push_tick();
    push_tick();
    drain_tones();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TONE_SAMPLES,
                CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4)));
      write_reg(CFG_GAP_SAMPLES,
                CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4)));
      write_reg(CFG_AMPLITUDE, CFG_DATA_W'((p == 1) ? 0 : $urandom_range(0, 32767)));
      if (p == 5) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
      random_phase(30, p == 3);
    end

    // back-to-back beats with no receiver stalls, full amplitude
    steady_flow = 1'b1;
    write_reg(CFG_TONE_SAMPLES, 16'd6);
    write_reg(CFG_GAP_SAMPLES, 16'd2);
    write_reg(CFG_AMPLITUDE, 16'd32767);
    push_load(14);
    push_load(3);
    repeat (16) push_tick();
    drain_tones();

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dtmf_pkg.sv
rtl/core/dtmf_sine_rom.sv
rtl/core/dtmf_key_fifo.sv
rtl/core/dtmf_sequence_generator_core.sv
tb/dtmf_sequence_generator_core_test.sv
